FILE: rtl/csem_pkg.sv
// Shared types and constants for the counting semaphore with priority wait queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package csem_pkg;

    localparam int ID_W       = 5;
    localparam int CNT_W      = 16;
    localparam int TICK_W     = 32;
    localparam int IN_PRIO_W  = 8;
    localparam int PRIO_W_MAX = 16;
    localparam int CFG_IDX_W  = 1;

    // Depth of the command queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_TAKE     = 2'd0,
        CMD_GIVE     = 2'd1,
        CMD_WITHDRAW = 2'd2,
        CMD_REINIT   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_PENDING  = 3'd2,
        ST_FULL     = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNT_CEIL    = 1'b0,
        REG_INITIAL_COUNT = 1'b1
    } t_reg_idx;

    // Classified command as it travels from front to back.
    typedef struct packed {
        t_cmd              cmd;
        logic [ID_W-1:0]   id;
        logic              id_ok;
        logic              wait_zero;
        logic              arm;
        logic [TICK_W-1:0] wake;
        logic              yield_ok;
    } t_item;

    // Operation requested of the wait queue.
    typedef struct packed {
        logic            ins;
        logic            rm_head;
        logic            rm_match;
        logic            clr;
        logic [ID_W-1:0] id;
    } t_q_cmd;

    // Wait queue status seen by the back end.
    typedef struct packed {
        logic            full;
        logic            empty;
        logic            found;
        logic [ID_W-1:0] head_id;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: rtl/csem_front.sv
// Front end: accepts input transactions, classifies them and buffers them.
// Depends on csem_pkg.
`default_nettype none

module csem_front #(
    parameter int MAX_TASKS = 32,
    parameter int PRIO_BITS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [1:0]                       i_cmd,
    input  wire  [csem_pkg::ID_W-1:0]        i_task_id,
    input  wire  [csem_pkg::IN_PRIO_W-1:0]   i_task_priority,
    input  wire  [csem_pkg::TICK_W-1:0]      i_wait_ticks,
    input  wire  [csem_pkg::TICK_W-1:0]      i_current_tick,
    input  wire  [csem_pkg::IN_PRIO_W-1:0]   i_running_priority,
    input  wire                              i_has_running,
    input  wire                              i_kernel_running,
    input  wire                              i_from_isr,
    output logic                             o_item_valid,
    output csem_pkg::t_item                  o_item,
    output logic [PRIO_BITS-1:0]             o_prio,
    output logic [PRIO_BITS-1:0]             o_run_prio,
    input  wire                              i_pop
);
    import csem_pkg::*;

    t_item                  r_item     [FIFO_DEPTH];
    logic [PRIO_BITS-1:0]   r_prio     [FIFO_DEPTH];
    logic [PRIO_BITS-1:0]   r_run_prio [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]     r_cnt, n_cnt;

    t_item                  cls;
    logic [PRIO_W_MAX-1:0]  prio_ext, run_prio_ext;
    logic                   push;

    // Classify: trim priorities, check id range, form the wake tick.
    always_comb begin
        prio_ext      = PRIO_W_MAX'(i_task_priority);
        run_prio_ext  = PRIO_W_MAX'(i_running_priority);
        cls.cmd       = t_cmd'(i_cmd);
        cls.id        = i_task_id;
        cls.id_ok     = (32'(i_task_id) < MAX_TASKS);
        cls.wait_zero = (i_wait_ticks == '0);
        cls.arm       = (i_wait_ticks != '1);
        cls.wake      = i_current_tick + i_wait_ticks;
        cls.yield_ok  = i_has_running && (i_from_isr || i_kernel_running);
    end

    assign o_stall      = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign push         = i_valid && !o_stall;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_item[r_rd_ptr];
    assign o_prio       = r_prio[r_rd_ptr];
    assign o_run_prio   = r_run_prio[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_item[r_wr_ptr]     <= cls;
            r_prio[r_wr_ptr]     <= prio_ext[PRIO_BITS-1:0];
            r_run_prio[r_wr_ptr] <= run_prio_ext[PRIO_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/csem_waitq.sv
// Priority-sorted wait queue built as a row of shifting cells, best entry first.
// Depends on csem_pkg.
`default_nettype none

module csem_waitq #(
    parameter int WAIT_DEPTH = 16,
    parameter int PRIO_BITS  = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  csem_pkg::t_q_cmd          i_qcmd,
    input  wire  [PRIO_BITS-1:0]      i_ins_prio,
    output csem_pkg::t_q_stat         o_qstat,
    output logic [PRIO_BITS-1:0]      o_head_prio
);
    import csem_pkg::*;

    logic [WAIT_DEPTH-1:0] r_v, n_v;
    logic [ID_W-1:0]       r_id   [WAIT_DEPTH];
    logic [PRIO_BITS-1:0]  r_prio [WAIT_DEPTH];
    logic [ID_W-1:0]       n_id   [WAIT_DEPTH];
    logic [PRIO_BITS-1:0]  n_prio [WAIT_DEPTH];

    logic [WAIT_DEPTH-1:0] keep, match, sel, prev_keep, nxt_v, prev_v, rm_mask;
    logic                  do_ins, do_rm;

    assign o_qstat.full    = r_v[WAIT_DEPTH-1];
    assign o_qstat.empty   = !r_v[0];
    assign o_qstat.found   = |match;
    assign o_qstat.head_id = r_id[0];
    assign o_head_prio     = r_prio[0];

    assign prev_keep = {keep[WAIT_DEPTH-2:0], 1'b1};
    assign prev_v    = {r_v[WAIT_DEPTH-2:0], 1'b1};
    assign nxt_v     = {1'b0, r_v[WAIT_DEPTH-1:1]};
    assign do_ins    = i_qcmd.ins && !r_v[WAIT_DEPTH-1];
    assign do_rm     = i_qcmd.rm_head || i_qcmd.rm_match;
    assign rm_mask   = i_qcmd.rm_head ? '1 : sel;

    for (genvar g = 0; g < WAIT_DEPTH; g++) begin : g_cell
        logic [ID_W-1:0]      prev_id, nxt_id;
        logic [PRIO_BITS-1:0] prev_prio, nxt_prio;

        assign keep[g]  = r_v[g] && (r_prio[g] <= i_ins_prio);
        assign match[g] = r_v[g] && (r_id[g] == i_qcmd.id);
        // first match: any match at or ahead of this cell
        assign sel[g]   = |match[g:0];

        if (g == 0) begin : g_first
            assign prev_id   = i_qcmd.id;
            assign prev_prio = i_ins_prio;
        end else begin : g_mid
            assign prev_id   = r_id[g-1];
            assign prev_prio = r_prio[g-1];
        end

        if (g == WAIT_DEPTH - 1) begin : g_last
            assign nxt_id   = r_id[g];
            assign nxt_prio = r_prio[g];
        end else begin : g_inner
            assign nxt_id   = r_id[g+1];
            assign nxt_prio = r_prio[g+1];
        end

        always_comb begin
            n_v[g]    = r_v[g];
            n_id[g]   = r_id[g];
            n_prio[g] = r_prio[g];
            if (i_qcmd.clr) begin
                n_v[g] = 1'b0;
            end else if (do_ins) begin
                if (!keep[g]) begin
                    if (prev_keep[g]) begin
                        // insertion point
                        n_v[g]    = 1'b1;
                        n_id[g]   = i_qcmd.id;
                        n_prio[g] = i_ins_prio;
                    end else begin
                        n_v[g]    = prev_v[g];
                        n_id[g]   = prev_id;
                        n_prio[g] = prev_prio;
                    end
                end
            end else if (do_rm && rm_mask[g]) begin
                n_v[g]    = nxt_v[g];
                n_id[g]   = nxt_id;
                n_prio[g] = nxt_prio;
            end
        end

        always_ff @(posedge i_clk) begin
            r_id[g]   <= n_id[g];
            r_prio[g] <= n_prio[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/csem_back.sv
// Back end: executes commands against the count and wait queue, holds the result.
// Depends on csem_pkg; drives csem_waitq through t_q_cmd.
`default_nettype none

module csem_back #(
    parameter int PRIO_BITS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [csem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [csem_pkg::CNT_W-1:0]       i_cfg_data,
    input  wire                              i_item_valid,
    input  csem_pkg::t_item                  i_item,
    input  wire  [PRIO_BITS-1:0]             i_prio,
    input  wire  [PRIO_BITS-1:0]             i_run_prio,
    output logic                             o_pop,
    output csem_pkg::t_q_cmd                 o_qcmd,
    output logic [PRIO_BITS-1:0]             o_ins_prio,
    input  csem_pkg::t_q_stat                i_qstat,
    input  wire  [PRIO_BITS-1:0]             i_head_prio,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [2:0]                       o_status,
    output logic                             o_woken_valid,
    output logic [csem_pkg::ID_W-1:0]        o_woken_task,
    output logic                             o_yield_needed,
    output logic                             o_arm_timer,
    output logic [csem_pkg::TICK_W-1:0]      o_expiry_tick,
    output logic [csem_pkg::CNT_W-1:0]       o_count_now
);
    import csem_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_max, r_init;
    logic              r_out_valid;
    t_status           r_status, n_status;
    logic              r_woken, n_woken;
    logic [ID_W-1:0]   r_woken_id, n_woken_id;
    logic              r_yield, n_yield;
    logic              r_arm, n_arm;
    logic [TICK_W-1:0] r_wake, n_wake;
    logic              fire;

    assign fire       = i_item_valid && (!r_out_valid || !i_stall);
    assign o_pop      = fire;
    assign o_ins_prio = i_prio;

    always_comb begin
        n_count       = r_count;
        n_status      = ST_OK;
        n_woken       = 1'b0;
        n_woken_id    = '0;
        n_yield       = 1'b0;
        n_arm         = 1'b0;
        n_wake        = '0;
        o_qcmd.ins      = 1'b0;
        o_qcmd.rm_head  = 1'b0;
        o_qcmd.rm_match = 1'b0;
        o_qcmd.clr      = 1'b0;
        o_qcmd.id       = i_item.id;
        if (fire) begin
            unique case (i_item.cmd)
                CMD_TAKE: begin
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end else if (i_item.wait_zero) begin
                        n_status = ST_TIMEOUT;
                    end else if (i_qstat.full || !i_item.id_ok) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        o_qcmd.ins = 1'b1;
                        n_status   = ST_PENDING;
                        n_arm      = i_item.arm;
                        n_wake     = i_item.arm ? i_item.wake : '0;
                    end
                end
                CMD_GIVE: begin
                    if (!i_qstat.empty) begin
                        o_qcmd.rm_head = 1'b1;
                        n_woken        = 1'b1;
                        n_woken_id     = i_qstat.head_id;
                        n_yield        = i_item.yield_ok && (i_head_prio < i_run_prio);
                    end else if (r_count >= r_max) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_WITHDRAW: begin
                    if (i_qstat.found) begin
                        o_qcmd.rm_match = 1'b1;
                        n_status        = ST_TIMEOUT;
                    end
                end
                CMD_REINIT: begin
                    n_count    = (r_init < r_max) ? r_init : r_max;
                    o_qcmd.clr = 1'b1;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_max       <= CNT_W'(1);
            r_init      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_COUNT_CEIL:    r_max  <= i_cfg_data;
                    REG_INITIAL_COUNT: r_init <= i_cfg_data;
                    default:           r_max  <= r_max;
                endcase
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status   <= n_status;
            r_woken    <= n_woken;
            r_woken_id <= n_woken_id;
            r_yield    <= n_yield;
            r_arm      <= n_arm;
            r_wake     <= n_wake;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_woken_valid  = r_woken;
    assign o_woken_task   = r_woken_id;
    assign o_yield_needed = r_yield;
    assign o_arm_timer    = r_arm;
    assign o_expiry_tick  = r_wake;
    // count after the item: the register updates on the same edge as the result
    assign o_count_now    = r_count;

endmodule

`default_nettype wire

FILE: rtl/counting_semaphore_priority_waitq.sv
// Counting semaphore with a priority-ordered wait queue of task ids. Take, give,
// withdraw-after-timeout and reinit commands arrive as valid/stall transactions and
// each produces exactly one result transaction. A front stage accepts a command,
// trims priorities, checks the task id range and forms the wake tick, then parks it
// in a two-entry command queue; the back stage executes one command per cycle,
// unless a held result is stalled, against the count and a row of WAIT_DEPTH
// sorted shift cells (lower priority number first, first in first out among
// equals) and holds the result in an output register. The command queue
// registers an accepted command and the back stage executes it from the queue
// head, writing the output register and the wait queue cells on the same edge;
// sustained throughput is one transaction per cycle while the result channel is
// not stalled. Up to three transactions are in flight (two queued, one held in
// the output register). Either side may stall without blocking the other until
// the command queue fills. Configuration (the count ceiling at index 0, the
// reinit count at index 1) must be written through i_cfg_we only while the
// block is idle; the block itself does not enforce this.
// Depends on csem_pkg, csem_front, csem_waitq and csem_back.
`default_nettype none

module counting_semaphore_priority_waitq #(
    parameter int WAIT_DEPTH = 16,
    parameter int MAX_TASKS  = 32,
    parameter int PRIO_BITS  = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration write port
    input  wire                              i_cfg_we,
    input  wire  [csem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [csem_pkg::CNT_W-1:0]       i_cfg_data,
    // command channel
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [1:0]                       i_cmd,
    input  wire  [csem_pkg::ID_W-1:0]        i_task_id,
    input  wire  [csem_pkg::IN_PRIO_W-1:0]   i_task_priority,
    input  wire  [csem_pkg::TICK_W-1:0]      i_wait_ticks,
    input  wire  [csem_pkg::TICK_W-1:0]      i_current_tick,
    input  wire  [csem_pkg::IN_PRIO_W-1:0]   i_running_priority,
    input  wire                              i_has_running,
    input  wire                              i_kernel_running,
    input  wire                              i_from_isr,
    // result channel
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [2:0]                       o_status,
    output logic                             o_woken_valid,
    output logic [csem_pkg::ID_W-1:0]        o_woken_task,
    output logic                             o_yield_needed,
    output logic                             o_arm_timer,
    output logic [csem_pkg::TICK_W-1:0]      o_expiry_tick,
    output logic [csem_pkg::CNT_W-1:0]       o_count_now
);
    import csem_pkg::*;

    logic                 item_valid;
    t_item                item;
    logic [PRIO_BITS-1:0] item_prio;
    logic [PRIO_BITS-1:0] item_run_prio;
    logic                 pop;
    t_q_cmd               qcmd;
    t_q_stat              qstat;
    logic [PRIO_BITS-1:0] ins_prio;
    logic [PRIO_BITS-1:0] head_prio;

    // Accept and classify; buffer up to two commands.
    csem_front #(
        .MAX_TASKS (MAX_TASKS),
        .PRIO_BITS (PRIO_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_cmd              (i_cmd),
        .i_task_id          (i_task_id),
        .i_task_priority    (i_task_priority),
        .i_wait_ticks       (i_wait_ticks),
        .i_current_tick     (i_current_tick),
        .i_running_priority (i_running_priority),
        .i_has_running      (i_has_running),
        .i_kernel_running   (i_kernel_running),
        .i_from_isr         (i_from_isr),
        .o_item_valid       (item_valid),
        .o_item             (item),
        .o_prio             (item_prio),
        .o_run_prio         (item_run_prio),
        .i_pop              (pop)
    );

    // Sorted wait queue: insert by priority, drop head or first matching id, or clear.
    csem_waitq #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .PRIO_BITS  (PRIO_BITS)
    ) u_waitq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qcmd      (qcmd),
        .i_ins_prio  (ins_prio),
        .o_qstat     (qstat),
        .o_head_prio (head_prio)
    );

    // Execute one command per cycle while the result is not stalled, and hold the result until taken.
    csem_back #(
        .PRIO_BITS (PRIO_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_item_valid   (item_valid),
        .i_item         (item),
        .i_prio         (item_prio),
        .i_run_prio     (item_run_prio),
        .o_pop          (pop),
        .o_qcmd         (qcmd),
        .o_ins_prio     (ins_prio),
        .i_qstat        (qstat),
        .i_head_prio    (head_prio),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_woken_valid  (o_woken_valid),
        .o_woken_task   (o_woken_task),
        .o_yield_needed (o_yield_needed),
        .o_arm_timer    (o_arm_timer),
        .o_expiry_tick  (o_expiry_tick),
        .o_count_now    (o_count_now)
    );

endmodule

`default_nettype wire
